// File: rtl/fpd_pkg.sv
// Shared types and constants for the flight phase detector.
package fpd_pkg;

  localparam int unsigned ThrW = 15;
  localparam int unsigned MarW = 16;
  localparam int unsigned AccW = 16;
  localparam int unsigned AltW = 24;
  localparam int unsigned StampW = 48;
  localparam int unsigned SeqW = 16;
  localparam int unsigned CfgW = 16;

  localparam logic [0:0] CfgThreshold = 1'b0;
  localparam logic [0:0] CfgMargin = 1'b1;

  localparam logic [1:0] EvIgnition = 2'd0;
  localparam logic [1:0] EvBurnout = 2'd1;
  localparam logic [1:0] EvChute = 2'd2;
  localparam logic [1:0] EvTouchdown = 2'd3;

  typedef enum logic [4:0] {
    PhReady     = 5'b00001,
    PhBurning   = 5'b00010,
    PhBurnout   = 5'b00100,
    PhChute     = 5'b01000,
    PhTouchdown = 5'b10000
  } phase_e;

  // Smoothed sample handed from the front end to the phase unit.
  typedef struct packed {
    logic signed [AccW-1:0] ax;
    logic signed [AccW-1:0] ay;
    logic signed [AccW-1:0] az;
    logic signed [AltW-1:0] alt;
    logic [StampW-1:0]      stamp;
    logic [SeqW-1:0]        seq;
  } smooth_t;

endpackage

// File: rtl/fpd_avg.sv
// Front end: moving window sums and serial division by the fill count.
module fpd_avg import fpd_pkg::*; #(
  parameter int unsigned Window = 8
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   valid_i,
  output logic                   stall_o,
  input  logic signed [AccW-1:0] accel_x_i,
  input  logic signed [AccW-1:0] accel_y_i,
  input  logic signed [AccW-1:0] accel_z_i,
  input  logic signed [AltW-1:0] altitude_i,
  input  logic [StampW-1:0]      stamp_us_i,
  input  logic [SeqW-1:0]        seq_number_i,
  output logic                   valid_o,
  input  logic                   stall_i,
  output smooth_t                data_o
);

  localparam int unsigned SlotW = (Window > 1) ? $clog2(Window) : 1;
  localparam int unsigned FillW = $clog2(Window + 1);
  localparam int unsigned GrowW = $clog2(Window);
  localparam int unsigned SumAW = AccW + GrowW;
  localparam int unsigned SumHW = AltW + GrowW;
  localparam int unsigned QW = AltW + GrowW;
  localparam int unsigned CntW = $clog2(QW + 1);

  logic [3*AccW-1:0] acc_mem [Window];
  logic [AltW-1:0]   alt_mem [Window];
  logic [3*AccW-1:0] old_acc_q;
  logic [AltW-1:0]   old_alt_q;

  logic signed [SumAW-1:0] sx_q, sy_q, sz_q;
  logic signed [SumHW-1:0] sh_q;
  logic [FillW-1:0] fill_q;
  logic [SlotW-1:0] slot_q;

  typedef enum logic [3:0] {
    StIdle = 4'b0001, StRead = 4'b0010, StDiv = 4'b0100, StOut = 4'b1000
  } st_e;
  st_e st_q;

  logic signed [AccW-1:0] ix_q, iy_q, iz_q;
  logic signed [AltW-1:0] ih_q;
  logic [StampW-1:0] stamp_q;
  logic [SeqW-1:0]   seq_q;

  // Divider lanes: magnitude, quotient, remainder, sign.
  logic [QW-1:0] num_q [4];
  logic [QW-1:0] rem_q [4];
  logic          neg_q [4];
  logic [CntW-1:0] cnt_q;
  logic [QW:0] trial [4];

  logic full;
  assign full = (fill_q == FillW'(Window));
  assign stall_o = (st_q != StIdle);
  assign valid_o = (st_q == StOut);

  always_ff @(posedge clk_i) begin
    if (valid_i && !stall_o) begin
      acc_mem[slot_q] <= {accel_z_i, accel_y_i, accel_x_i};
      alt_mem[slot_q] <= altitude_i;
    end
  end

  always_ff @(posedge clk_i) begin
    old_acc_q <= acc_mem[slot_q];
    old_alt_q <= alt_mem[slot_q];
  end

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      trial[i] = {rem_q[i], num_q[i][QW-1]} - {{(QW+1-FillW){1'b0}}, fill_q};
    end
  end

  logic signed [SumAW-1:0] nx, ny, nz;
  logic signed [SumHW-1:0] nh;
  always_comb begin
    nx = sx_q + SumAW'(ix_q);
    ny = sy_q + SumAW'(iy_q);
    nz = sz_q + SumAW'(iz_q);
    nh = sh_q + SumHW'(ih_q);
    if (full) begin
      nx = nx - SumAW'($signed(old_acc_q[AccW-1:0]));
      ny = ny - SumAW'($signed(old_acc_q[2*AccW-1:AccW]));
      nz = nz - SumAW'($signed(old_acc_q[3*AccW-1:2*AccW]));
      nh = nh - SumHW'($signed(old_alt_q));
    end
  end

  function automatic logic [QW-1:0] mag(input logic signed [QW-1:0] v);
    return v[QW-1] ? QW'(-v) : v;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle;
      sx_q <= '0; sy_q <= '0; sz_q <= '0; sh_q <= '0;
      fill_q <= '0;
      slot_q <= '0;
      cnt_q <= '0;
    end else begin
      unique case (st_q)
        StIdle: begin
          if (valid_i) st_q <= StRead;
        end
        StRead: begin
          sx_q <= nx; sy_q <= ny; sz_q <= nz; sh_q <= nh;
          if (!full) fill_q <= fill_q + 1'b1;
          slot_q <= (slot_q == SlotW'(Window - 1)) ? '0 : slot_q + 1'b1;
          cnt_q <= '0;
          st_q <= StDiv;
        end
        StDiv: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == CntW'(QW - 1)) st_q <= StOut;
        end
        StOut: begin
          if (!stall_i) st_q <= StIdle;
        end
        default: st_q <= StIdle;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_q == StIdle && valid_i) begin
      ix_q <= accel_x_i; iy_q <= accel_y_i; iz_q <= accel_z_i;
      ih_q <= altitude_i; stamp_q <= stamp_us_i; seq_q <= seq_number_i;
    end
    if (st_q == StRead) begin
      num_q[0] <= mag(QW'(nx)); neg_q[0] <= nx[SumAW-1];
      num_q[1] <= mag(QW'(ny)); neg_q[1] <= ny[SumAW-1];
      num_q[2] <= mag(QW'(nz)); neg_q[2] <= nz[SumAW-1];
      num_q[3] <= mag(QW'(nh)); neg_q[3] <= nh[SumHW-1];
      for (int i = 0; i < 4; i++) rem_q[i] <= '0;
    end
    if (st_q == StDiv) begin
      // Restoring division, one quotient bit per cycle, shifted into num.
      for (int i = 0; i < 4; i++) begin
        if (!trial[i][QW]) begin
          rem_q[i] <= trial[i][QW-1:0];
          num_q[i] <= {num_q[i][QW-2:0], 1'b1};
        end else begin
          rem_q[i] <= {rem_q[i][QW-2:0], num_q[i][QW-1]};
          num_q[i] <= {num_q[i][QW-2:0], 1'b0};
        end
      end
    end
  end

  logic [QW-1:0] qv [4];
  always_comb begin
    for (int i = 0; i < 4; i++) qv[i] = neg_q[i] ? QW'(-num_q[i]) : num_q[i];
    data_o.ax = qv[0][AccW-1:0];
    data_o.ay = qv[1][AccW-1:0];
    data_o.az = qv[2][AccW-1:0];
    data_o.alt = qv[3][AltW-1:0];
    data_o.stamp = stamp_q;
    data_o.seq = seq_q;
  end

`ifndef ASSERT_OFF
  a_fill_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FillW'(Window)) else $error("fill overflow");
  a_fill_nz: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == StDiv) |-> (fill_q != '0)) else $error("divide by zero fill");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && stall_i) |=> valid_o) else $error("result dropped");
`endif

endmodule

// File: rtl/fpd_queue.sv
// Two-entry queue between front end and phase unit.
module fpd_queue import fpd_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    valid_i,
  output logic    stall_o,
  input  smooth_t data_i,
  output logic    valid_o,
  input  logic    stall_i,
  output smooth_t data_o
);

  smooth_t mem_q [2];
  logic rd_q, wr_q;
  logic [1:0] cnt_q;
  logic push, pop;

  assign stall_o = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign push = valid_i && !stall_o;
  assign pop = valid_o && !stall_i;
  assign data_o = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_q <= 1'b0; wr_q <= 1'b0; cnt_q <= '0;
    end else begin
      if (push) wr_q <= ~wr_q;
      if (pop) rd_q <= ~rd_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

`ifndef ASSERT_OFF
  a_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 2'd2) else $error("queue count");
  a_ptr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd1) |-> (rd_q != wr_q)) else $error("queue pointers");
  a_ptr2: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q != 2'd1) |-> (rd_q == wr_q)) else $error("queue pointers");
`endif

endmodule

// File: rtl/fpd_phase.sv
// Back end: squared norm, phase machine and result sequencing.
module fpd_phase import fpd_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic [ThrW-1:0]          thr_i,
  input  logic [MarW-1:0]          margin_i,
  input  logic                     valid_i,
  output logic                     stall_o,
  input  smooth_t                  data_i,
  output logic                     valid_o,
  input  logic                     stall_i,
  output logic                     kind_o,
  output logic signed [AccW-1:0]   avg_accel_x_o,
  output logic signed [AccW-1:0]   avg_accel_y_o,
  output logic signed [AccW-1:0]   avg_accel_z_o,
  output logic signed [AltW-1:0]   avg_altitude_o,
  output logic [StampW-1:0]        out_stamp_us_o,
  output logic [SeqW-1:0]          out_seq_number_o,
  output logic [1:0]               event_code_o,
  output logic [StampW-1:0]        elapsed_us_o,
  output logic                     last_o
);

  typedef enum logic [6:0] {
    StIdle = 7'b0000001, StSqX = 7'b0000010, StSqY = 7'b0000100,
    StSqZ = 7'b0001000, StDecide = 7'b0010000, StRead = 7'b0100000,
    StEvent = 7'b1000000
  } st_e;
  st_e st_q;
  phase_e ph_q;

  smooth_t cur_q;
  logic [33:0] n2_q;
  logic [31:0] sq_q;
  logic [29:0] t2_q;
  logic [AccW-1:0] mag_x;
  logic [StampW-1:0] ign_stamp_q;
  logic signed [AltW-1:0] ign_alt_q;
  logic ev_q;
  logic [1:0] code_q;

  logic signed [AccW-1:0] opnd;
  always_comb begin
    unique case (st_q)
      StSqX: opnd = cur_q.ax;
      StSqY: opnd = cur_q.ay;
      default: opnd = cur_q.az;
    endcase
    mag_x = opnd[AccW-1] ? AccW'(-opnd) : opnd;
  end

  logic [33:0] t9;
  logic signed [AltW:0] dalt;
  logic [AltW:0] adalt;
  assign t9 = {t2_q, 3'b000} + {4'b0, t2_q};
  assign dalt = (AltW+1)'(cur_q.alt) - (AltW+1)'(ign_alt_q);
  assign adalt = dalt[AltW] ? (AltW+1)'(-dalt) : dalt;

  assign stall_o = (st_q != StIdle);
  assign valid_o = (st_q == StRead) || (st_q == StEvent);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle;
      ph_q <= PhReady;
      ign_stamp_q <= '0;
      ign_alt_q <= '0;
    end else begin
      unique case (st_q)
        StIdle: if (valid_i) st_q <= StSqX;
        StSqX: st_q <= StSqY;
        StSqY: st_q <= StSqZ;
        StSqZ: st_q <= StDecide;
        StDecide: begin
          st_q <= StRead;
          unique case (ph_q)
            PhReady: if (n2_q + {2'b0, sq_q} > {4'b0, t2_q}) begin
              ph_q <= PhBurning;
              ign_stamp_q <= cur_q.stamp;
              ign_alt_q <= cur_q.alt;
            end
            PhBurning: if (n2_q + {2'b0, sq_q} < {4'b0, t2_q}) ph_q <= PhBurnout;
            PhBurnout: if (n2_q + {2'b0, sq_q} > t9) ph_q <= PhChute;
            PhChute: if (adalt < (AltW+1)'(margin_i)) ph_q <= PhTouchdown;
            default: ;
          endcase
        end
        StRead: if (!stall_i) st_q <= ev_q ? StEvent : StIdle;
        StEvent: if (!stall_i) st_q <= StIdle;
        default: st_q <= StIdle;
      endcase
    end
  end

  logic [33:0] nsum;
  assign nsum = n2_q + {2'b0, sq_q};

  always_ff @(posedge clk_i) begin
    if (st_q == StIdle && valid_i) begin
      cur_q <= data_i;
      n2_q <= '0;
      t2_q <= 30'(thr_i) * 30'(thr_i);
    end
    if (st_q == StSqX || st_q == StSqY || st_q == StSqZ) begin
      // Multiply this cycle, accumulate the previous product.
      sq_q <= 32'(mag_x) * 32'(mag_x);
      if (st_q != StSqX) n2_q <= nsum;
    end
    if (st_q == StDecide) begin
      ev_q <= 1'b0;
      unique case (ph_q)
        PhReady: if (nsum > {4'b0, t2_q}) begin ev_q <= 1'b1; code_q <= EvIgnition; end
        PhBurning: if (nsum < {4'b0, t2_q}) begin ev_q <= 1'b1; code_q <= EvBurnout; end
        PhBurnout: if (nsum > t9) begin ev_q <= 1'b1; code_q <= EvChute; end
        PhChute: if (adalt < (AltW+1)'(margin_i)) begin
          ev_q <= 1'b1; code_q <= EvTouchdown;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    kind_o = (st_q == StEvent);
    out_stamp_us_o = cur_q.stamp;
    out_seq_number_o = cur_q.seq;
    avg_accel_x_o = kind_o ? '0 : cur_q.ax;
    avg_accel_y_o = kind_o ? '0 : cur_q.ay;
    avg_accel_z_o = kind_o ? '0 : cur_q.az;
    avg_altitude_o = kind_o ? '0 : cur_q.alt;
    event_code_o = kind_o ? code_q : EvIgnition;
    elapsed_us_o = kind_o ? cur_q.stamp - ign_stamp_q : '0;
    last_o = kind_o || !ev_q;
  end

`ifndef ASSERT_OFF
  a_td_term: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ph_q == PhTouchdown) |=> (ph_q == PhTouchdown)) else $error("left touchdown");
  a_ev_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == StEvent) |-> ev_q) else $error("event without cause");
  a_ign_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == StEvent && code_q == EvIgnition) |-> (elapsed_us_o == '0))
    else $error("ignition elapsed nonzero");
`endif

endmodule

// File: rtl/flight_phase_detector.sv
// Top level of the flight phase detector.
// A telemetry request holds the front end while it takes the request, updates the window
// sums, runs one divide step per quotient bit of the serial divide by the fill count and
// hands the smoothed sample to the queue, so it takes no new request before it is through
// with the last one. The back end then squares the three components in three states,
// decides the phase in a fourth and presents the smoothed reading, followed by at most one
// event once the reading is taken. A two-entry queue lets the front end take the next
// sample while the back end still waits on its results.
module flight_phase_detector import fpd_pkg::*; #(
  parameter int unsigned WINDOW = 8
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [0:0]             cfg_idx_i,
  input  logic [CfgW-1:0]        cfg_data_i,
  input  logic                   valid_i,
  output logic                   stall_o,
  input  logic signed [AccW-1:0] accel_x_i,
  input  logic signed [AccW-1:0] accel_y_i,
  input  logic signed [AccW-1:0] accel_z_i,
  input  logic signed [AltW-1:0] altitude_i,
  input  logic [StampW-1:0]      stamp_us_i,
  input  logic [SeqW-1:0]        seq_number_i,
  output logic                   valid_o,
  input  logic                   stall_i,
  output logic                   kind_o,
  output logic signed [AccW-1:0] avg_accel_x_o,
  output logic signed [AccW-1:0] avg_accel_y_o,
  output logic signed [AccW-1:0] avg_accel_z_o,
  output logic signed [AltW-1:0] avg_altitude_o,
  output logic [StampW-1:0]      out_stamp_us_o,
  output logic [SeqW-1:0]        out_seq_number_o,
  output logic [1:0]             event_code_o,
  output logic [StampW-1:0]      elapsed_us_o,
  output logic                   last_o
);

  logic [ThrW-1:0] thr_q;
  logic [MarW-1:0] margin_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= ThrW'(2560);
      margin_q <= MarW'(150);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgThreshold: thr_q <= cfg_data_i[ThrW-1:0];
        CfgMargin: margin_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic f_valid, f_stall, b_valid, b_stall;
  smooth_t f_data, b_data;

  fpd_avg #(.Window(WINDOW)) u_avg (
    .clk_i, .rst_ni, .valid_i, .stall_o,
    .accel_x_i, .accel_y_i, .accel_z_i, .altitude_i, .stamp_us_i, .seq_number_i,
    .valid_o(f_valid), .stall_i(f_stall), .data_o(f_data)
  );

  fpd_queue u_queue (
    .clk_i, .rst_ni, .valid_i(f_valid), .stall_o(f_stall), .data_i(f_data),
    .valid_o(b_valid), .stall_i(b_stall), .data_o(b_data)
  );

  fpd_phase u_phase (
    .clk_i, .rst_ni, .thr_i(thr_q), .margin_i(margin_q),
    .valid_i(b_valid), .stall_o(b_stall), .data_i(b_data),
    .valid_o, .stall_i, .kind_o, .avg_accel_x_o, .avg_accel_y_o, .avg_accel_z_o,
    .avg_altitude_o, .out_stamp_us_o, .out_seq_number_o, .event_code_o,
    .elapsed_us_o, .last_o
  );

endmodule
